// ===== rtl/ps2mpt_pkg.sv =====
// Package for the PS/2 mouse packet tracker: shared types, codes and constants.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package ps2mpt_pkg;

   // Stream and register widths.
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 80;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   // Byte codes of the PS/2 protocol.
   localparam logic [7:0] AckByte  = 8'hFA;
   localparam int         XSignBit = 4;
   localparam int         YSignBit = 5;

   // Event kinds carried on the request tuser bit.
   typedef enum logic {
      MODE_RECEIVED = 1'b0,
      MODE_COMMAND  = 1'b1
   } mode_type;

   // Register indexes (byte address divided by four).
   typedef enum logic [1:0] {
      CSR_SPEED_SHIFT   = 2'd0,
      CSR_SCREEN_WIDTH  = 2'd1,
      CSR_SCREEN_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [3:0]  SpeedShiftReset   = 4'd6;
   localparam logic [12:0] ScreenWidthReset  = 13'd80;
   localparam logic [12:0] ScreenHeightReset = 13'd25;
   localparam logic [15:0] FineXReset        = 16'd40;
   localparam logic [15:0] FineYReset        = 16'd12;
   localparam logic [7:0]  PendingAckMax     = 8'hFF;
   localparam logic [11:0] ScreenMax         = 12'hFFF;

   typedef struct packed {
      logic [3:0]  speed_shift;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
   } cfg_type;

   // A decoded packet together with the updated fine positions.
   typedef struct packed {
      logic [2:0]         buttons;
      logic signed [8:0]  delta_x;
      logic signed [9:0]  delta_y;
      logic [15:0]        position_x;
      logic [15:0]        position_y;
   } pkt_type;

endpackage

// ===== rtl/ps2mpt_csr.sv =====
// Configuration register bank of the PS/2 mouse packet tracker (APB-style port).
// Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ps2mpt_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [ps2mpt_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [ps2mpt_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                csr_pready,
   output ps2mpt_pkg::cfg_type                 cfg
);
   import ps2mpt_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_SPEED_SHIFT:   cfg_in.speed_shift   = csr_pwdata[3:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[12:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[12:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_shift   <= SpeedShiftReset;
         cfg_ff.screen_width  <= ScreenWidthReset;
         cfg_ff.screen_height <= ScreenHeightReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         CSR_SPEED_SHIFT:   csr_prdata = {28'd0, cfg_ff.speed_shift};
         CSR_SCREEN_WIDTH:  csr_prdata = {19'd0, cfg_ff.screen_width};
         CSR_SCREEN_HEIGHT: csr_prdata = {19'd0, cfg_ff.screen_height};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ps2mpt_track.sv =====
// Byte tracker: acknowledge filtering, packet assembly, delta decode and
// saturating position accumulation, ending in the packet register.
// Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                mode,
   input  logic [7:0]          data_byte,
   input  logic [3:0]          speed_shift,
   input  logic                pkt_take,
   output logic                pkt_valid,
   output ps2mpt_pkg::pkt_type pkt
);
   import ps2mpt_pkg::*;

   logic [7:0]  pending_ff, pending_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  byte0_ff, byte0_in;
   logic [7:0]  byte1_ff, byte1_in;
   logic [15:0] fine_x_ff, fine_x_in;
   logic [15:0] fine_y_ff, fine_y_in;
   logic        valid_ff, valid_in;
   pkt_type     pkt_ff, pkt_in;
   logic        complete;

   logic signed [8:0]  delta_x;
   logic signed [8:0]  raw_y;
   logic signed [9:0]  delta_y;
   logic [15:0]        new_x;
   logic [15:0]        new_y;

   // Adds a shifted delta to a position and clamps the sum to 0..65535.
   function automatic logic [15:0] accumulate(input logic [15:0] pos,
                                              input logic signed [9:0] delta,
                                              input logic [3:0] shift);
      logic signed [25:0] step;
      logic signed [25:0] sum;
      step = $signed({{16{delta[9]}}, delta}) <<< shift;
      sum  = $signed({10'd0, pos}) + step;
      if (sum[25])
         return 16'd0;
      else if (sum[24:16] != 9'd0)
         return 16'hFFFF;
      else
         return sum[15:0];
   endfunction

   // A zero magnitude byte decodes to zero whatever its sign bit says.
   assign delta_x = (byte1_ff == 8'd0) ? 9'sd0 : $signed({byte0_ff[XSignBit], byte1_ff});
   assign raw_y   = (data_byte == 8'd0) ? 9'sd0 : $signed({byte0_ff[YSignBit], data_byte});
   assign delta_y = -$signed({raw_y[8], raw_y});
   assign new_x   = accumulate(fine_x_ff, {delta_x[8], delta_x}, speed_shift);
   assign new_y   = accumulate(fine_y_ff, delta_y, speed_shift);

   always_comb begin
      pending_in = pending_ff;
      index_in   = index_ff;
      byte0_in   = byte0_ff;
      byte1_in   = byte1_ff;
      fine_x_in  = fine_x_ff;
      fine_y_in  = fine_y_ff;
      complete   = 1'b0;
      if (accept) begin
         if (mode_type'(mode) == MODE_COMMAND) begin
            if (pending_ff != PendingAckMax)
               pending_in = pending_ff + 8'd1;
         end else if (pending_ff != 8'd0 && data_byte == AckByte) begin
            pending_in = pending_ff - 8'd1;
         end else begin
            pending_in = 8'd0;
            case (index_ff)
               2'd0: begin
                  byte0_in = data_byte;
                  index_in = 2'd1;
               end
               2'd1: begin
                  byte1_in = data_byte;
                  index_in = 2'd2;
               end
               default: begin
                  index_in  = 2'd0;
                  fine_x_in = new_x;
                  fine_y_in = new_y;
                  complete  = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      pkt_in.buttons    = byte0_ff[2:0];
      pkt_in.delta_x    = delta_x;
      pkt_in.delta_y    = delta_y;
      pkt_in.position_x = new_x;
      pkt_in.position_y = new_y;
      if (complete)
         valid_in = 1'b1;
      else if (pkt_take)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 8'd0;
         index_ff   <= 2'd0;
         fine_x_ff  <= FineXReset;
         fine_y_ff  <= FineYReset;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         index_ff   <= index_in;
         fine_x_ff  <= fine_x_in;
         fine_y_ff  <= fine_y_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      if (complete)
         pkt_ff <= pkt_in;
   end

   assign pkt_valid = valid_ff;
   assign pkt       = pkt_ff;

endmodule

// ===== rtl/ps2mpt_scale.sv =====
// Screen scaling stage and result register of the PS/2 mouse packet tracker.
// Depends on ps2mpt_pkg.
`timescale 1ns / 1ps

module ps2mpt_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pkt_valid,
   input  ps2mpt_pkg::pkt_type                 pkt,
   input  logic [12:0]                         screen_width,
   input  logic [12:0]                         screen_height,
   output logic                                pkt_take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ps2mpt_pkg::RspDataWidth-1:0] rsp_tdata
);
   import ps2mpt_pkg::*;

   logic                    valid_ff, valid_in;
   logic [RspDataWidth-1:0] data_ff, data_in;
   logic                    room;
   logic [28:0]             prod_x;
   logic [28:0]             prod_y;
   logic [11:0]             screen_x;
   logic [11:0]             screen_y;

   // The result register takes a packet when empty or when its transfer completes.
   assign room     = !valid_ff || rsp_tready;
   assign pkt_take = pkt_valid && room;

   assign prod_x = pkt.position_x * screen_width;
   assign prod_y = pkt.position_y * screen_height;

   // Oversized screen settings can push the scaled value past 4095; clamp it.
   assign screen_x = prod_x[28] ? ScreenMax : prod_x[27:16];
   assign screen_y = prod_y[28] ? ScreenMax : prod_y[27:16];

   assign data_in = {2'b00, screen_y, screen_x, pkt.position_y, pkt.position_x,
                     pkt.delta_y, pkt.delta_x, pkt.buttons};

   always_comb begin
      if (room)
         valid_in = pkt_valid;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pkt_take)
         data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// PS/2 mouse packet tracker, top level.
// A completed packet is held in the packet register, then in the result register.
// Throughput: one request per cycle; the tracker register and the scaling multiply
// register form a two-stage pipeline, and only a stalled result holds off requests.
// Reset (synchronous): no pending acknowledges, packet at byte 0, position (40, 12),
// speed shift 6, screen 80 x 25, no result pending.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ps2mpt_pkg::ReqDataWidth-1:0] req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [37:22] position_x,
   // [53:38] position_y, [65:54] screen_x, [77:66] screen_y, [79:78] zero
   output logic [ps2mpt_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ps2mpt_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [ps2mpt_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [ps2mpt_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ps2mpt_pkg::*;

   cfg_type cfg;
   pkt_type pkt;
   logic    pkt_valid;
   logic    pkt_take;
   logic    accept;

   assign req_tready = !pkt_valid || pkt_take;
   assign accept     = req_tvalid && req_tready;

   ps2mpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ps2mpt_track u_track (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (req_tuser),
      .data_byte   (req_tdata),
      .speed_shift (cfg.speed_shift),
      .pkt_take    (pkt_take),
      .pkt_valid   (pkt_valid),
      .pkt         (pkt)
   );

   ps2mpt_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .pkt_valid     (pkt_valid),
      .pkt           (pkt),
      .screen_width  (cfg.screen_width),
      .screen_height (cfg.screen_height),
      .pkt_take      (pkt_take),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for ps2_mouse_packet_tracker: streams mouse events, predicts each
// packet report in place and compares it with the rsp stream, over several register settings.
// Depends on ps2mpt_pkg and the ps2_mouse_packet_tracker RTL only.
`timescale 1ns / 1ps

module testbench;
   import ps2mpt_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int MaxReported = 10;
   localparam int PosMax      = 65535;
   localparam int LongHold    = 120;

   typedef struct {
      mode_type   mode;
      logic [7:0] data_byte;
      bit         drain_first;
   } mouse_event_type;

   typedef struct packed {
      logic [2:0]        buttons;
      logic signed [8:0] delta_x;
      logic signed [9:0] delta_y;
      logic [15:0]       position_x;
      logic [15:0]       position_y;
      logic [11:0]       screen_x;
      logic [11:0]       screen_y;
   } pointer_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;  // [7:0] data_byte
   logic                    req_tuser = 1'b0; // [0] mode
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [37:22] position_x,
   // [53:38] position_y, [65:54] screen_x, [77:66] screen_y, [79:78] zero
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   ps2_mouse_packet_tracker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Tracker state and register copies, kept in step with accepted transfers.
   logic [3:0]  cfg_shift  = SpeedShiftReset;
   logic [12:0] cfg_width  = ScreenWidthReset;
   logic [12:0] cfg_height = ScreenHeightReset;
   logic [7:0]  pending_acks = '0;
   logic [1:0]  packet_phase = '0;
   logic [7:0]  held_bytes [2] = '{8'h00, 8'h00};
   logic [15:0] fine_x = FineXReset;
   logic [15:0] fine_y = FineYReset;

   mouse_event_type    pending_events [$];
   pointer_report_type expected_reports [$];
   mouse_event_type    next_event;
   pointer_report_type observed_report;
   pointer_report_type wanted_report;

   int   queued_total = 0;
   int   fault_count = 0;
   int   cycle_count = 0;
   int   reports_seen = 0;
   bit   req_taken = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   next_hold_at = 60;
   logic [7:0] rx_cycle = '0;

   function automatic int signed_delta(input logic [7:0] magnitude, input logic negative);
      if (magnitude == 8'd0) return 0;
      return negative ? int'(magnitude) - 256 : int'(magnitude);
   endfunction

   function automatic logic [15:0] step_position(input logic [15:0] pos, input int delta);
      int sum;
      sum = int'(pos) + delta * (1 << cfg_shift);
      if (sum < 0) sum = 0;
      else if (sum > PosMax) sum = PosMax;
      return sum[15:0];
   endfunction

   function automatic logic [11:0] scale_to_screen(input logic [15:0] pos,
                                                   input logic [12:0] size);
      logic [31:0] scaled;
      scaled = (32'(pos) * 32'(size)) >> 16;
      return (scaled > 32'(ScreenMax)) ? ScreenMax : scaled[11:0];
   endfunction

   function automatic string describe(input pointer_report_type r);
      return $sformatf("buttons=%0d dx=%0d dy=%0d pos=(%0d,%0d) screen=(%0d,%0d)",
                       r.buttons, r.delta_x, r.delta_y, r.position_x, r.position_y,
                       r.screen_x, r.screen_y);
   endfunction

   task automatic advance_tracker(input mode_type mode, input logic [7:0] b);
      pointer_report_type rpt;
      int dx;
      int dy;
      if (mode == MODE_COMMAND) begin
         if (pending_acks != PendingAckMax) pending_acks++;
         return;
      end
      if (pending_acks != 8'd0) begin
         if (b == AckByte) begin
            pending_acks--;
            return;
         end
         pending_acks = '0;
      end
      if (packet_phase < 2'd2) begin
         held_bytes[packet_phase] = b;
         packet_phase++;
         return;
      end
      packet_phase = '0;
      dx = signed_delta(held_bytes[1], held_bytes[0][XSignBit]);
      dy = -signed_delta(b, held_bytes[0][YSignBit]);
      fine_x = step_position(fine_x, dx);
      fine_y = step_position(fine_y, dy);
      rpt.buttons    = held_bytes[0][2:0];
      rpt.delta_x    = dx[8:0];
      rpt.delta_y    = dy[9:0];
      rpt.position_x = fine_x;
      rpt.position_y = fine_y;
      rpt.screen_x   = scale_to_screen(fine_x, cfg_width);
      rpt.screen_y   = scale_to_screen(fine_y, cfg_height);
      expected_reports.push_back(rpt);
   endtask

   // Transfer bookkeeping, prediction and checking, all on the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         req_taken = req_tvalid && req_tready && !reset;
         if (req_taken) advance_tracker(mode_type'(req_tuser), req_tdata);
         if (!reset && rsp_tvalid && rsp_tready) begin
            observed_report.buttons    = rsp_tdata[2:0];
            observed_report.delta_x    = rsp_tdata[11:3];
            observed_report.delta_y    = rsp_tdata[21:12];
            observed_report.position_x = rsp_tdata[37:22];
            observed_report.position_y = rsp_tdata[53:38];
            observed_report.screen_x   = rsp_tdata[65:54];
            observed_report.screen_y   = rsp_tdata[77:66];
            reports_seen++;
            if (expected_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= MaxReported)
                  $display("unexpected report: %s", describe(observed_report));
            end else begin
               wanted_report = expected_reports.pop_front();
               if (observed_report != wanted_report) begin
                  fault_count++;
                  if (fault_count <= MaxReported)
                     $display("report mismatch: expected %s, got %s",
                              describe(wanted_report), describe(observed_report));
               end
            end
         end
      end
   end

   // Sender: bursts of transfers with random gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_events.size() == 0 ||
                      (pending_events[0].drain_first && expected_reports.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            next_event = pending_events.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_event.data_byte;
            req_tuser  <= next_event.mode;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: short random stalls, stall-free stretches, and now and then a long hold.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left == 0 && reports_seen >= next_hold_at) begin
            hold_left = LongHold;
            next_hold_at += 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rx_cycle[7:6] == 2'b00) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_transfer(input csr_index_type idx, input logic write_en,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_settings();
      logic [31:0] rdata;
      logic [31:0] want [3];
      csr_index_type idx;
      want[0] = 32'(cfg_shift);
      want[1] = 32'(cfg_width);
      want[2] = 32'(cfg_height);
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_transfer(idx, 1'b0, '0, rdata);
         if (rdata != want[i]) begin
            fault_count++;
            if (fault_count <= MaxReported)
               $display("register %s read back %0d, expected %0d", idx.name(), rdata, want[i]);
         end
      end
   endtask

   task automatic load_settings(input logic [3:0] shift, input logic [12:0] width,
                                input logic [12:0] height);
      logic [31:0] unused;
      csr_transfer(CSR_SPEED_SHIFT, 1'b1, 32'(shift), unused);
      csr_transfer(CSR_SCREEN_WIDTH, 1'b1, 32'(width), unused);
      csr_transfer(CSR_SCREEN_HEIGHT, 1'b1, 32'(height), unused);
      cfg_shift  = shift;
      cfg_width  = width;
      cfg_height = height;
      verify_settings();
   endtask

   // Returns once the block has taken everything and delivered every report, plus a margin
   // for a byte that is still in flight but causes no report.
   task automatic wait_until_idle();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_event(input mode_type mode, input logic [7:0] data_byte);
      mouse_event_type ev;
      ev.mode        = mode;
      ev.data_byte   = data_byte;
      ev.drain_first = ($urandom_range(0, 99) == 0);
      pending_events.push_back(ev);
      queued_total++;
   endtask

   task automatic queue_packet(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
      queue_event(MODE_RECEIVED, b0);
      queue_event(MODE_RECEIVED, b1);
      queue_event(MODE_RECEIVED, b2);
   endtask

   function automatic logic [7:0] pick_delta_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'h80;
         4: return AckByte;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_mixed_traffic(input int count);
      int target;
      int kind;
      int cmds;
      logic [7:0] bytes [3];
      target = queued_total + count;
      while (queued_total < target) begin
         kind = $urandom_range(0, 99);
         bytes[0] = 8'($urandom);
         bytes[1] = pick_delta_byte();
         bytes[2] = pick_delta_byte();
         if (kind < 65) begin
            queue_packet(bytes[0], bytes[1], bytes[2]);
         end else if (kind < 80) begin
            cmds = $urandom_range(1, 4);
            repeat (cmds) queue_event(MODE_COMMAND, 8'($urandom));
            repeat ($urandom_range(0, cmds + 1)) queue_event(MODE_RECEIVED, AckByte);
            queue_packet(bytes[0], bytes[1], bytes[2]);
         end else if (kind < 92) begin
            // Commands and acknowledges falling between the bytes of one packet.
            for (int n = 0; n < 3; n++) begin
               if ($urandom_range(0, 2) == 0) begin
                  queue_event(MODE_COMMAND, 8'($urandom));
                  if ($urandom_range(0, 1) == 1) queue_event(MODE_RECEIVED, AckByte);
               end
               queue_event(MODE_RECEIVED, bytes[n]);
            end
         end else begin
            repeat ($urandom_range(1, 3))
               queue_event(mode_type'($urandom_range(0, 1)), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      verify_settings();

      // Zero delta bytes, with and without the sign bits set.
      queue_packet(8'h08, 8'h00, 8'h00);
      queue_packet(8'h3F, 8'h00, 8'h00);
      // Largest moves in both directions on both axes.
      queue_packet(8'h37, 8'h01, 8'h01);
      queue_packet(8'hC0, 8'hFF, 8'hFF);
      queue_packet(8'h30, 8'h80, 8'h80);
      // One acknowledge is swallowed; the packet byte after it clears the count.
      queue_event(MODE_COMMAND, 8'hFF);
      queue_event(MODE_COMMAND, 8'hF4);
      queue_event(MODE_RECEIVED, AckByte);
      queue_packet(8'h12, AckByte, 8'h05);
      // Commands and an acknowledge in the middle of a packet leave it intact.
      queue_event(MODE_RECEIVED, 8'h21);
      queue_event(MODE_COMMAND, 8'h00);
      queue_event(MODE_RECEIVED, 8'h7F);
      queue_event(MODE_COMMAND, 8'hF3);
      queue_event(MODE_RECEIVED, AckByte);
      queue_event(MODE_RECEIVED, 8'h40);

      wait_until_idle();
      load_settings(4'd0, 13'd4096, 13'd4096);
      queue_mixed_traffic(100);

      wait_until_idle();
      load_settings(4'd15, 13'd1, 13'd1);
      // Overfill the acknowledge count: exactly 255 acknowledges are swallowed afterwards,
      // so the next 0xFA is taken as packet data.
      repeat (258) queue_event(MODE_COMMAND, 8'($urandom));
      repeat (255) queue_event(MODE_RECEIVED, AckByte);
      queue_packet(AckByte, 8'h10, 8'h22);
      queue_mixed_traffic(60);

      // Screen sizes outside the documented range.
      wait_until_idle();
      load_settings(4'd3, 13'd0, 13'd8191);
      queue_mixed_traffic(80);

      for (int p = 0; p < 3; p++) begin
         wait_until_idle();
         load_settings(4'($urandom_range(0, 15)), 13'($urandom_range(1, 4096)),
                       13'($urandom_range(1, 4096)));
         queue_mixed_traffic(55);
      end

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
